### rtl/tdpt_pkg.sv
package tdpt_pkg;

  // width of the tested number and of the prime count
  localparam int NUMBER_WIDTH = 31;
  localparam int ORD_WIDTH    = 27;

  // trial divisor reaches at most floor(sqrt(n)) + 1
  localparam int DIV_WIDTH = (NUMBER_WIDTH + 1) / 2 + 1;
  // running square of the divisor, (floor(sqrt(n)) + 1)^2 < 2^(NUMBER_WIDTH + 1)
  localparam int SQ_WIDTH  = NUMBER_WIDTH + 2;
  // bit counter of the serial remainder
  localparam int CNT_WIDTH = $clog2(NUMBER_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_TEST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;        // take a new candidate, divisor back to two
    logic start_div;   // clear remainder, arm bit counter
    logic step;        // one restoring remainder step
    logic advance;     // next divisor and its square
    logic mark_prime;
    logic mark_comp;
    logic emit;        // move verdict into the result register
  } cmd_t;

  typedef struct packed {
    logic below_two;   // candidate below two
    logic sq_gt;       // divisor squared exceeds candidate
    logic last_bit;    // final remainder step in progress
    logic rem_zero;
    logic res_busy;    // result register held by a stalled receiver
  } stat_t;

endpackage

### rtl/tdpt_ctrl.sv
module tdpt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cand_valid,
  output logic            cand_stall,
  input  tdpt_pkg::stat_t stat,
  output tdpt_pkg::cmd_t  cmd
);
  import tdpt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cand_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.below_two || stat.sq_gt) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (stat.last_bit) begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        if (stat.rem_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (!stat.res_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cand_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        cand_stall = 1'b0;
        cmd.load   = cand_valid;
      end
      ST_CHECK: begin
        if (stat.below_two) begin
          cmd.mark_comp = 1'b1;
        end else if (stat.sq_gt) begin
          cmd.mark_prime = 1'b1;
        end else begin
          cmd.start_div = 1'b1;
        end
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
      end
      ST_TEST: begin
        if (stat.rem_zero) begin
          cmd.mark_comp = 1'b1;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.emit = !stat.res_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/tdpt_dp.sv
module tdpt_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  tdpt_pkg::cmd_t                     cmd,
  output tdpt_pkg::stat_t                    stat,
  input  logic [tdpt_pkg::NUMBER_WIDTH-1:0]  candidate,
  input  logic [tdpt_pkg::ORD_WIDTH-1:0]     base,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic                               is_prime,
  output logic [tdpt_pkg::ORD_WIDTH-1:0]     prime_ordinal
);
  import tdpt_pkg::*;

  logic [NUMBER_WIDTH-1:0] num;
  logic [NUMBER_WIDTH-1:0] nsh;
  logic [DIV_WIDTH-1:0]    div;
  logic [SQ_WIDTH-1:0]     sq;
  logic [DIV_WIDTH-1:0]    rem;
  logic [CNT_WIDTH-1:0]    cnt;
  logic                    verdict;
  logic [ORD_WIDTH-1:0]    primes_found;
  logic [ORD_WIDTH-1:0]    primes_found_next;

  logic [DIV_WIDTH:0]      rem_shift;
  logic [DIV_WIDTH:0]      rem_sub;
  logic                    rem_ge;

  // restoring remainder, one candidate bit per step from the top
  assign rem_shift = {rem, nsh[NUMBER_WIDTH-1]};
  assign rem_ge    = rem_shift >= {1'b0, div};
  assign rem_sub   = rem_shift - {1'b0, div};

  assign primes_found_next = primes_found + ORD_WIDTH'(1);

  assign stat.below_two = (num[NUMBER_WIDTH-1:1] == '0);
  assign stat.sq_gt     = sq > SQ_WIDTH'(num);
  assign stat.last_bit  = (cnt == '0);
  assign stat.rem_zero  = (rem == '0);
  assign stat.res_busy  = res_valid && res_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= candidate;
      div <= DIV_WIDTH'(2);
      sq  <= SQ_WIDTH'(4);
    end
    if (cmd.start_div) begin
      rem <= '0;
      nsh <= num;
      cnt <= CNT_WIDTH'(NUMBER_WIDTH - 1);
    end
    if (cmd.step) begin
      rem <= rem_ge ? rem_sub[DIV_WIDTH-1:0] : rem_shift[DIV_WIDTH-1:0];
      nsh <= {nsh[NUMBER_WIDTH-2:0], 1'b0};
      cnt <= cnt - CNT_WIDTH'(1);
    end
    if (cmd.advance) begin
      // (d + 1)^2 = d^2 + 2d + 1
      div <= div + DIV_WIDTH'(1);
      sq  <= sq + SQ_WIDTH'({div, 1'b1});
    end
    if (cmd.mark_prime) begin
      verdict <= 1'b1;
    end else if (cmd.mark_comp) begin
      verdict <= 1'b0;
    end
    if (cmd.emit) begin
      is_prime      <= verdict;
      prime_ordinal <= verdict ? base + primes_found_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid    <= 1'b0;
      primes_found <= '0;
    end else begin
      if (cmd.emit) begin
        res_valid <= 1'b1;
        if (verdict) begin
          primes_found <= primes_found_next;
        end
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/trial_division_prime_test_core.sv
// Trial-division primality tester. Each candidate item gets one result item: is_prime,
// and for a prime its ordinal, i.e. base_index plus the number of primes found since
// reset, wrapping at 2^27 (zero for a non-prime). Divisors 2, 3, ... are tried while
// d*d <= candidate; the remainder is formed by a bit-serial restoring unit, one
// candidate bit per cycle, so every divisor tried costs one bound check, 31
// remainder steps and one zero test. The number k of divisors tried is the smallest
// divisor minus one for a composite and floor(sqrt(candidate)) - 1 for a prime, so
// the largest 31-bit primes try the most divisors and candidates below four none.
// One item is in work at a time; the finished result sits in an output register,
// so a stalled receiver only holds the block once the next verdict is ready.
// A base_index write takes effect from the next prime reported and does not clear
// the count.
module trial_division_prime_test_core (
  input  logic                               clk,
  input  logic                               rst,
  // candidate channel
  input  logic                               cand_valid,
  output logic                               cand_stall,
  input  logic [tdpt_pkg::NUMBER_WIDTH-1:0]  candidate,
  // result channel
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic                               is_prime,
  output logic [tdpt_pkg::ORD_WIDTH-1:0]     prime_ordinal,
  // base index write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tdpt_pkg::ORD_WIDTH-1:0]     base_index
);
  import tdpt_pkg::*;

  cmd_t                 cmd;
  stat_t                stat;
  logic [ORD_WIDTH-1:0] base;

  // the user must write the register only while idle; the block does not enforce it, and is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      base <= base_index;
    end
  end

  // sequencer: bound check, remainder steps, zero test, result hand-off
  tdpt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // divisor, running square, serial remainder, prime count and result register
  tdpt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .candidate     (candidate),
    .base          (base),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .is_prime      (is_prime),
    .prime_ordinal (prime_ordinal)
  );

endmodule

### tb/prime_verdict_checker.sv
module prime_verdict_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cand_valid,
  input  logic                              cand_stall,
  input  logic [tdpt_pkg::NUMBER_WIDTH-1:0] candidate,
  input  logic                              res_valid,
  input  logic                              res_stall,
  input  logic                              is_prime,
  input  logic [tdpt_pkg::ORD_WIDTH-1:0]    prime_ordinal,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [tdpt_pkg::ORD_WIDTH-1:0]    base_index,
  output int                                failures,
  output int                                outstanding,
  output int                                checked,
  output int                                primes_reported
);

  localparam int NW = tdpt_pkg::NUMBER_WIDTH;
  localparam int OW = tdpt_pkg::ORD_WIDTH;

  typedef struct {
    logic [NW-1:0] number;
    logic          prime;
    logic [OW-1:0] ordinal;
  } verdict_t;

  verdict_t      verdict_q[$];
  logic [OW-1:0] base_setting;
  logic [OW-1:0] prime_count;

  // n is at least two and no divisor d with d*d <= n divides n
  function automatic bit survives_trial_division(input longint unsigned n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic note_failure(input string what);
    failures = failures + 1;
    if (failures <= 10) $display("mismatch: %s", what);
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst) begin
      verdict_q.delete();
      base_setting    = '0;
      prime_count     = '0;
      failures        = 0;
      checked         = 0;
      primes_reported = 0;
    end else begin
      if (cfg_valid && cfg_ready) base_setting = base_index;
      // results first, so a stray result never meets an item taken at the same edge
      if (res_valid && !res_stall) begin
        checked = checked + 1;
        if (is_prime === 1'b1) primes_reported = primes_reported + 1;
        if (verdict_q.size() == 0) begin
          note_failure($sformatf("result is_prime=%0b ordinal=%0d with no item waiting",
                                 is_prime, prime_ordinal));
        end else begin
          want = verdict_q.pop_front();
          if (is_prime !== want.prime || prime_ordinal !== want.ordinal) begin
            note_failure($sformatf({"candidate %0d: expected is_prime=%0b ordinal=%0d,",
                                    " got is_prime=%0b ordinal=%0d"},
                                   want.number, want.prime, want.ordinal,
                                   is_prime, prime_ordinal));
          end
        end
      end
      if (cand_valid && !cand_stall) begin
        want.number = candidate;
        want.prime  = survives_trial_division(64'(candidate));
        if (want.prime) begin
          prime_count  = prime_count + 1'b1;
          want.ordinal = base_setting + prime_count;
        end else begin
          want.ordinal = '0;
        end
        verdict_q.push_back(want);
      end
    end
    outstanding <= verdict_q.size();
  end

endmodule

### tb/tb.sv
module tb;

  localparam int NW           = tdpt_pkg::NUMBER_WIDTH;
  localparam int OW           = tdpt_pkg::ORD_WIDTH;
  localparam int RANDOM_ITEMS = 70;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 100;

  logic          clk;
  logic          rst        = 1'b1;
  // candidate channel, driven here
  logic          cand_valid = 1'b0;
  logic          cand_stall;
  logic [NW-1:0] candidate  = '0;
  // result channel, stall driven here
  logic          res_valid;
  logic          res_stall  = 1'b0;
  logic          is_prime;
  logic [OW-1:0] prime_ordinal;
  // base index write channel
  logic          cfg_valid  = 1'b0;
  logic          cfg_ready;
  logic [OW-1:0] base_index = '0;

  int failures;
  int outstanding;
  int checked;
  int primes_reported;

  // pacing knobs for the sender and the receiver, and a count of base index writes
  bit feed_calm    = 1'b0;
  bit sink_calm    = 1'b0;
  int hold_off_len = 0;
  int base_writes  = 0;

  // directed candidates: below two, tiny primes, prime squares, twin-factor product,
  // largest 16- and 20-bit primes, top of range and alternating bit patterns
  logic [NW-1:0] directed_cands [18] = '{
    0, 1, 2, 3, 4, 5, 9, 25, 97, 121, 10403, 65521, 65535, 1048573,
    2147483646, 2147483645, 1431655765, 715827882
  };

  trial_division_prime_test_core dut (
    .clk           (clk),
    .rst           (rst),
    .cand_valid    (cand_valid),
    .cand_stall    (cand_stall),
    .candidate     (candidate),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .is_prime      (is_prime),
    .prime_ordinal (prime_ordinal),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .base_index    (base_index)
  );

  prime_verdict_checker verdicts (
    .clk             (clk),
    .rst             (rst),
    .cand_valid      (cand_valid),
    .cand_stall      (cand_stall),
    .candidate       (candidate),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .is_prime        (is_prime),
    .prime_ordinal   (prime_ordinal),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .base_index      (base_index),
    .failures        (failures),
    .outstanding     (outstanding),
    .checked         (checked),
    .primes_reported (primes_reported)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random candidate mix, weighted towards numbers that test quickly:
  // trial division of a prime near 2^31 tries every divisor up to its square root
  function automatic logic [NW-1:0] draw_candidate();
    int unsigned   pick;
    int unsigned   factor;
    logic [NW-1:0] value;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      // small numbers, primes and composites alike
      value = NW'($urandom_range(0, 4095));
    end else if (pick < 70) begin
      // full-width number forced onto a small factor, so it ends early
      factor = $urandom_range(2, 7);
      value  = NW'($urandom);
      value  = NW'(value - value % factor);
    end else if (pick < 85) begin
      value = NW'($urandom_range(4096, 65535));
    end else begin
      // product of two odd numbers, smallest factor at most 255
      value = NW'((2 * $urandom_range(1, 127) + 1) * (2 * $urandom_range(1, 16383) + 1));
    end
    return value;
  endfunction

  // offer one item, holding it steady until the block takes it
  task automatic send_candidate(input logic [NW-1:0] number);
    int gap;
    gap = feed_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cand_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cand_valid <= 1'b1;
    candidate  <= number;
    do @(posedge clk); while (cand_stall);
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain_results();
    cand_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // base index only changes while the block is idle
  task automatic write_base_index(input logic [OW-1:0] value);
    drain_results();
    cfg_valid  <= 1'b1;
    base_index <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    base_writes = base_writes + 1;
  endtask

  // receiver: random stall before each item, one long hold-off when asked
  initial begin : result_sink
    int gap;
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_len > 0 && !held) begin
        gap  = hold_off_len;
        held = 1'b1;
      end else begin
        gap = sink_calm ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        res_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        res_stall <= 1'b0;
      end
      do @(posedge clk); while (!res_valid);
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed items under the reset base index of zero
    foreach (directed_cands[i]) send_candidate(directed_cands[i]);

    // all-ones base, so the next ordinals wrap past 2^27
    write_base_index('1);
    // receiver holds off while quick items keep coming, filling the block
    hold_off_len = HOLD_CYCLES;
    send_candidate(2);
    send_candidate(3);
    send_candidate(4);
    send_candidate(5);
    send_candidate(7);
    send_candidate(8);
    send_candidate(11);
    send_candidate(13);

    // random base index, then the random mix with changing pace
    write_base_index(OW'($urandom));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 20 == 0) begin
        feed_calm = (i == 40) || ($urandom_range(0, 3) == 0);
        sink_calm = (i == 40) || ($urandom_range(0, 3) == 0);
      end
      send_candidate(draw_candidate());
    end

    // back to a zero base, count carries on
    write_base_index('0);
    feed_calm = 1'b0;
    sink_calm = 1'b0;
    repeat (5) send_candidate(draw_candidate());

    drain_results();
    // quiet tail to catch any stray result
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d candidates, %0d of them prime, from directed extremes and a random mix",
             checked, primes_reported);
    $display("base index written %0d times (all ones, random, zero), one long receiver hold-off",
             base_writes);
    if (failures == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, several times the slowest expected run
  initial begin : watchdog
    #50_000_000;
    $display("timeout with %0d results still outstanding", outstanding);
    $display("status: fail");
    $finish;
  end

endmodule
